// ===== design/assert_macros.svh =====
// Assertion macros shared by the rms meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define RMSM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rms_meter assertion failed");

// Implication checked on every clock edge outside reset.
`define RMSM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rms_meter assertion failed");

`endif

// ===== design/rmsm_pkg.sv =====
// Types and fixed constants of the rms meter.
`default_nettype none

package rmsm_pkg;

    localparam int SAMPLE_W   = 16;  // Q1.15 sample
    localparam int RMS_W      = 16;  // Q1.15 unsigned result
    localparam int SCNT_W     = 11;  // reported sample count
    localparam int SQ_W       = 31;  // square of a Q1.15 sample, at most 2^30
    localparam int RAD_W      = 32;  // radicand register, two bits per step
    localparam int SREM_W     = 20;  // partial remainder of the root
    localparam int SQRT_STEPS = 16;  // one result bit per step

    // Input request
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_in;

    // Result request
    typedef struct packed {
        logic [RMS_W-1:0]  rms;
        logic [SCNT_W-1:0] sample_count;
        logic              overflow;
    } t_out;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic acc;        // square the incoming sample
        logic div_init;   // clear the divider remainder
        logic div_step;   // one quotient bit
        logic sqrt_init;  // load the mean into the root unit
        logic sqrt_step;  // one root bit
        logic out_load;   // move the result out, clear the block state
    } t_cmd;

endpackage

`default_nettype wire

// ===== design/rmsm_dp.sv =====
// Datapath: square and accumulate, restoring divider, digit-by-digit root, result register.
`default_nettype none

module rmsm_dp #(
    parameter int MAX_SAMPLES = 1024,
    parameter int CNT_W       = 11,
    parameter int SUM_W       = 41
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rmsm_pkg::t_in i_in,
    input  wire rmsm_pkg::t_cmd i_cmd,
    output rmsm_pkg::t_out     o_out
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

    // Square stage
    logic signed [2*rmsm_pkg::SAMPLE_W-1:0] product;
    logic [rmsm_pkg::SQ_W-1:0]              r_sq;
    logic                                   r_pend;

    // Block state; r_sum doubles as the dividend / quotient shift register
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic [CNT_W-1:0] r_rem, n_rem;

    // Root unit
    logic [rmsm_pkg::RAD_W-1:0]  r_rad, n_rad;
    logic [rmsm_pkg::RMS_W-1:0]  r_root, n_root;
    logic [rmsm_pkg::SREM_W-1:0] r_srem, n_srem;

    // Divider step
    logic [CNT_W:0] div_trial;
    logic [CNT_W:0] div_diff;
    logic           div_ge;

    // Root step
    logic [rmsm_pkg::SREM_W-1:0] sq_shift;
    logic [rmsm_pkg::SREM_W-1:0] sq_trial;
    logic [rmsm_pkg::SREM_W-1:0] sq_diff;
    logic                        sq_ge;

    logic [rmsm_pkg::SCNT_W+CNT_W-1:0] cnt_ext;
    rmsm_pkg::t_out                    r_out;

    assign product = i_in.sample * i_in.sample;

    assign div_trial = {r_rem, r_sum[SUM_W-1]};
    assign div_ge    = div_trial >= {1'b0, r_cnt};
    assign div_diff  = div_trial - {1'b0, r_cnt};

    assign sq_shift = {r_srem[rmsm_pkg::SREM_W-3:0], r_rad[rmsm_pkg::RAD_W-1 -: 2]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = sq_shift >= sq_trial;
    assign sq_diff  = sq_shift - sq_trial;

    assign cnt_ext = {{rmsm_pkg::SCNT_W{1'b0}}, r_cnt};

    // Next state of sum, count, flag and divider
    always_comb begin
        n_sum = r_sum;
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        n_rem = r_rem;
        if (r_pend) begin
            if (r_cnt != MAX_CNT) begin
                n_sum = r_sum + SUM_W'(r_sq);
                n_cnt = r_cnt + CNT_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
        if (i_cmd.div_init) begin
            n_rem = '0;
        end
        if (i_cmd.div_step) begin
            n_rem = div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
            n_sum = {r_sum[SUM_W-2:0], div_ge};
        end
        if (i_cmd.out_load) begin
            n_sum = '0;
            n_cnt = '0;
            n_ovf = 1'b0;
        end
    end

    // Next state of the root unit; the mean never exceeds 2^30
    always_comb begin
        n_rad  = r_rad;
        n_root = r_root;
        n_srem = r_srem;
        if (i_cmd.sqrt_init) begin
            n_rad  = {1'b0, r_sum[rmsm_pkg::RAD_W-2:0]};
            n_root = '0;
            n_srem = '0;
        end else if (i_cmd.sqrt_step) begin
            n_rad  = {r_rad[rmsm_pkg::RAD_W-3:0], 2'b00};
            n_root = {r_root[rmsm_pkg::RMS_W-2:0], sq_ge};
            n_srem = sq_ge ? sq_diff : sq_shift;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_sum  <= '0;
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_pend <= i_cmd.acc;
            r_sum  <= n_sum;
            r_cnt  <= n_cnt;
            r_ovf  <= n_ovf;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_sq <= product[rmsm_pkg::SQ_W-1:0];
        end
        r_rem  <= n_rem;
        r_rad  <= n_rad;
        r_root <= n_root;
        r_srem <= n_srem;
        if (i_cmd.out_load) begin
            r_out.rms          <= r_root;
            r_out.sample_count <= cnt_ext[rmsm_pkg::SCNT_W-1:0];
            r_out.overflow     <= r_ovf;
        end
    end

    assign o_out = r_out;

endmodule

`default_nettype wire

// ===== design/rmsm_ctrl.sv =====
// Controller: sequences accumulation, division, root and result handshake.
`default_nettype none

module rmsm_ctrl #(
    parameter int SUM_W = 41
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire logic    i_last,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_ready,
    output rmsm_pkg::t_cmd o_cmd
);

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] DIV_END  = STEP_W'(SUM_W - 1);
    localparam logic [STEP_W-1:0] SQRT_END = STEP_W'(rmsm_pkg::SQRT_STEPS - 1);

    localparam logic [2:0] S_ACC   = 3'd0;
    localparam logic [2:0] S_DRAIN = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SQI   = 3'd3;
    localparam logic [2:0] S_SQRT  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_valid, n_valid;
    logic              accept;
    logic              out_free;

    assign accept   = i_valid && (r_state == S_ACC);
    assign out_free = !r_valid || i_ready;

    // State transitions and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_ACC: begin
                o_cmd.acc = accept;
                if (accept && i_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.div_init = 1'b1;
                n_step         = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
                if (r_step == DIV_END) begin
                    n_state = S_SQI;
                end
            end
            S_SQI: begin
                o_cmd.sqrt_init = 1'b1;
                n_step          = '0;
                n_state         = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_step          = r_step + STEP_W'(1);
                if (r_step == SQRT_END) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    // Result valid: set on load, cleared when taken
    always_comb begin
        n_valid = r_valid;
        if (o_cmd.out_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    assign o_ready = (r_state == S_ACC);
    assign o_valid = r_valid;

endmodule

`default_nettype wire

// ===== design/rms_meter.sv =====
// Block rms meter: one sample per cycle while accumulating; a closing divide and root produce each result.
// Throughput: one sample a cycle while a block accumulates.
// After a last sample, the one-bit-a-cycle divider runs its SUM_W steps, then the 16-step
// square root, before the result is loaded.
// No sample is taken meanwhile; an untaken result stalls input once the next one is ready.
// Reset (synchronous, active low) clears the sum, the count, the flag and the controller.
`default_nettype none
`include "assert_macros.svh"

module rms_meter #(
    parameter int MAX_SAMPLES = 1024
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire rmsm_pkg::t_in i_in,
    output logic               o_valid,
    input  wire logic          i_ready,
    output rmsm_pkg::t_out     o_out
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = rmsm_pkg::SQ_W - 1 + CNT_W;
    localparam bit CNT_WRAPS = (MAX_SAMPLES > 2047);  // reported count is masked to 11 bits

    rmsm_pkg::t_cmd cmd;

    rmsm_ctrl #(
        .SUM_W (SUM_W)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_in.last),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    rmsm_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_out   (o_out)
    );

    // A last sample closes the block: no sample is taken in the next cycle
    `RMSM_ASSERT_IMP(a_busy_after_last, i_clk, i_rst_n, i_valid && o_ready && i_in.last, !o_ready)
    // The root of a mean of Q1.15 squares never exceeds full scale
    `RMSM_ASSERT(a_rms_range, i_clk, i_rst_n, !o_valid || (o_out.rms <= 16'd32768))
    // Every reported block holds at least one sample
    `RMSM_ASSERT(a_count_nonzero, i_clk, i_rst_n, !o_valid || CNT_WRAPS || (|o_out.sample_count))

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for rms_meter: random and directed sample blocks against a block RMS predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int BLOCK_MAX    = 1024;
    localparam int RANDOM_ITEMS = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 20;   // results seen before the long receiver hold
    localparam int SETTLE       = 100;  // cycles after the last result
    localparam int MAX_PRINTS   = 50;

    typedef enum logic [1:0] {
        IDLE_SEND_LIGHT,  // sender idles rarely, receiver often
        IDLE_SEND_HEAVY,  // sender idles often, receiver rarely
        IDLE_NONE         // both sides run flat out
    } t_idle_phase;

    // One queued request; drain holds it back until every result is in
    typedef struct packed {
        rmsm_pkg::t_in req;
        logic          drain;
    } t_pending;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_ready;
    rmsm_pkg::t_in  i_in    = '0;
    logic           o_valid;
    logic           i_ready = 1'b0;
    rmsm_pkg::t_out o_out;

    t_pending       pending_q[$];
    rmsm_pkg::t_out rms_expected_q[$];
    t_pending       next_req;
    rmsm_pkg::t_out want;

    t_idle_phase phase        = IDLE_SEND_LIGHT;
    int unsigned total_items  = 0;
    int unsigned n_sent       = 0;
    int unsigned lasts_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned errors       = 0;
    int unsigned hold_left    = 0;
    bit          hold_done    = 1'b0;

    // Predictor state: running sum of squares, sample count, drop flag
    longint unsigned blk_sum      = 0;
    int unsigned     blk_count    = 0;
    bit              blk_overflow = 1'b0;

    rms_meter #(
        .MAX_SAMPLES(BLOCK_MAX)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_in   (i_in),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_out  (o_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_PRINTS) begin
            $display("%0t mismatch: %s", $realtime, what);
        end
    endtask

    // Floor of the square root, one result bit at a time from the top
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 16; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Accumulate one sample; on the last one queue the block's RMS result
    task automatic accumulate_sample(input rmsm_pkg::t_in s);
        longint unsigned mag;
        int              val;
        rmsm_pkg::t_out  res;
        val = int'(s.sample);
        mag = (val < 0) ? longint'(-val) : longint'(val);
        if (blk_count < BLOCK_MAX) begin
            blk_sum += mag * mag;
            blk_count++;
        end else begin
            blk_overflow = 1'b1;
        end
        if (s.last) begin
            res.rms          = rmsm_pkg::RMS_W'(floor_sqrt(blk_sum / blk_count));
            res.sample_count = rmsm_pkg::SCNT_W'(blk_count);
            res.overflow     = blk_overflow;
            rms_expected_q.push_back(res);
            blk_sum      = 0;
            blk_count    = 0;
            blk_overflow = 1'b0;
        end
    endtask

    function automatic int idle_pct(input t_idle_phase ph, input bit is_sender);
        case (ph)
            IDLE_SEND_LIGHT: return is_sender ? 8 : 46;
            IDLE_SEND_HEAVY: return is_sender ? 46 : 8;
            default:         return 0;
        endcase
    endfunction

    // Mix of full-scale, small and fully random sample values
    function automatic logic [rmsm_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 255));
            3:       return 16'(-int'($urandom_range(1, 256)));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic add_req(input logic [rmsm_pkg::SAMPLE_W-1:0] smp, input bit lst,
                           input bit drn);
        t_pending p;
        p.req.sample = smp;
        p.req.last   = lst;
        p.drain      = drn;
        pending_q.push_back(p);
        total_items++;
    endtask

    task automatic add_block(input int len, input bit full_scale, input bit drn);
        for (int i = 0; i < len; i++) begin
            add_req(full_scale ? 16'h8000 : pick_sample(), i == len - 1, drn && i == 0);
        end
    endtask

    // Sender: holds valid and payload until accepted, otherwise idles at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_in    <= '0;
        end else begin
            if (i_valid && o_ready) begin
                n_sent++;
                if (i_in.last) begin
                    lasts_sent++;
                end
            end
            if (!i_valid || o_ready) begin
                if (pending_q.size() > 0
                        && !(pending_q[0].drain && results_seen < lasts_sent)
                        && $urandom_range(99) >= idle_pct(phase, 1'b1)) begin
                    next_req = pending_q.pop_front();
                    i_in    <= next_req.req;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            if (n_sent < total_items / 3) begin
                phase <= IDLE_SEND_LIGHT;
            end else if (n_sent < 2 * total_items / 3) begin
                phase <= IDLE_SEND_HEAVY;
            end else begin
                phase <= IDLE_NONE;
            end
        end
    end

    // Receiver: random stalls, plus one long hold so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= idle_pct(phase, 1'b0));
        end
    end

    // Monitor: check results first, then predict from accepted samples
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (rms_expected_q.size() == 0) begin
                    report_mismatch("result with none expected");
                end else begin
                    want = rms_expected_q.pop_front();
                    if (o_out.rms !== want.rms) begin
                        report_mismatch($sformatf("rms got %0d want %0d",
                                                  o_out.rms, want.rms));
                    end
                    if (o_out.sample_count !== want.sample_count) begin
                        report_mismatch($sformatf("sample_count got %0d want %0d",
                                                  o_out.sample_count, want.sample_count));
                    end
                    if (o_out.overflow !== want.overflow) begin
                        report_mismatch($sformatf("overflow got %0b want %0b",
                                                  o_out.overflow, want.overflow));
                    end
                end
                results_seen <= results_seen + 1;
            end
            if (i_valid && o_ready) begin
                accumulate_sample(i_in);
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int rand_items;
        int len;
        bit long_done;
        rand_items = 0;
        long_done  = 1'b0;

        // Single-sample blocks at the extremes
        add_req(16'h8000, 1'b1, 1'b0);
        add_req(16'h7FFF, 1'b1, 1'b0);
        add_req(16'h0000, 1'b1, 1'b0);
        add_req(16'h0001, 1'b1, 1'b0);
        add_req(16'hFFFF, 1'b1, 1'b0);
        // Mixed signs, alternating bit patterns, small values
        add_req(16'h7FFF, 1'b0, 1'b0);
        add_req(16'h8000, 1'b1, 1'b0);
        add_req(16'h5555, 1'b0, 1'b0);
        add_req(16'hAAAA, 1'b1, 1'b0);
        add_req(16'd100, 1'b0, 1'b0);
        add_req(-16'sd200, 1'b0, 1'b0);
        add_req(16'd300, 1'b1, 1'b0);
        add_req(16'h0000, 1'b0, 1'b0);
        add_req(16'h0000, 1'b0, 1'b0);
        add_req(16'h0003, 1'b1, 1'b0);

        // Random blocks, mostly short; sender pauses for a full drain first
        add_block($urandom_range(1, 8), 1'b0, 1'b1);
        while (rand_items < RANDOM_ITEMS) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
            add_block(len, 1'b0, 1'b0);
            rand_items += len;
            if (!long_done && rand_items >= RANDOM_ITEMS / 2) begin
                long_done = 1'b1;
                // Full-scale block that fills to the maximum length, then overflows
                add_block(BLOCK_MAX + $urandom_range(1, 5), 1'b1, 1'b1);
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || i_valid) @(negedge i_clk);
        while (results_seen < lasts_sent) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (rms_expected_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", rms_expected_q.size()));
        end

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
